// ----- design/rmm_pkg.sv -----
package rmm_pkg;

  localparam int NumLanes = 4;
  localparam int NumTerms = 4;
  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = 4;
  localparam int NumStages = 5;

  localparam logic [31:0] OneBits     = 32'h3F80_0000;
  localparam logic [31:0] ZeroBits    = 32'h0000_0000;
  localparam logic [31:0] NegZeroBits = 32'h8000_0000;
  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;
  localparam logic [7:0]  ExpMax      = 8'hFF;

  // Reset contents of the right matrix: the identity.
  localparam logic [NumRegs-1:0][63:0] CfgReset = '{
    64'h3F80_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_3F80_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h3F80_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_3F80_0000
  };

  // Choice of the third addend of each column sum.
  typedef enum logic [1:0] {
    THIRD_PROD,
    THIRD_TRANS,
    THIRD_NONE
  } third_sel_e;

  typedef struct packed {
    logic       affine;
    logic [1:0] row;
  } ctrl_t;

  // Multiplier state between the mantissa product and the rounding stage.
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [11:0] esum;
    logic [47:0]        prod;
  } mul_raw_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == ExpMax) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == ExpMax) && (x[22:0] == 23'd0);
  endfunction

  // Biased exponent (1 for subnormals) and mantissa with hidden bit.
  function automatic logic [31:0] unpack(input logic [31:0] x);
    logic [7:0]  e;
    logic [23:0] m;
    e = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    m = {(x[30:23] != 8'd0), x[22:0]};
    return {e, m};
  endfunction

  // Round to nearest even and pack. The mantissa has its leading one at bit 47
  // and the value is mant / 2^47 * 2^(e - 127).
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [11:0] e,
                                             input logic [47:0] mant);
    logic [11:0] sh;
    logic [47:0] m;
    logic        sticky;
    logic [23:0] keep;
    logic        rnd;
    logic        st;
    logic [7:0]  ef;
    logic [30:0] body;
    logic        up;
    sh     = 12'd0;
    m      = mant;
    sticky = 1'b0;
    ef     = 8'd0;
    if (e >= 12'sd255) begin
      return {sign, ExpMax, 23'd0};
    end
    if (e >= 12'sd1) begin
      ef = e[7:0];
    end else begin
      sh = 12'(12'sd1 - e);
      if (sh >= 12'd48) begin
        m      = '0;
        sticky = |mant;
      end else begin
        m      = mant >> sh[5:0];
        sticky = |(mant & ((48'd1 << sh[5:0]) - 48'd1));
      end
    end
    keep = m[47:24];
    rnd  = m[23];
    st   = (|m[22:0]) | sticky;
    up   = rnd & (st | keep[0]);
    body = {ef, keep[22:0]} + 31'(up);
    return {sign, body};
  endfunction

  // First multiplier stage: classification and the mantissa product.
  function automatic mul_raw_t mul_pre(input logic [31:0] a, input logic [31:0] b);
    mul_raw_t r;
    logic [31:0] ua;
    logic [31:0] ub;
    logic        za;
    logic        zb;
    ua     = unpack(a);
    ub     = unpack(b);
    za     = (a[30:0] == 31'd0);
    zb     = (b[30:0] == 31'd0);
    r.sign = a[31] ^ b[31];
    r.nan  = is_nan(a) | is_nan(b) | (is_inf(a) & zb) | (za & is_inf(b));
    r.inf  = is_inf(a) | is_inf(b);
    r.zero = za | zb;
    r.esum = 12'({4'd0, ua[31:24]}) + 12'({4'd0, ub[31:24]}) - 12'sd173;
    r.prod = ua[23:0] * ub[23:0];
    return r;
  endfunction

  // Second multiplier stage: normalise and round.
  function automatic logic [31:0] mul_post(input mul_raw_t r);
    logic [5:0] msb;
    msb = 6'd0;
    if (r.nan) return CanonNan;
    if (r.inf) return {r.sign, ExpMax, 23'd0};
    if (r.zero) return {r.sign, 31'd0};
    for (int i = 0; i < 48; i++) begin
      if (r.prod[i]) msb = 6'(i);
    end
    return round_pack(r.sign, r.esum + 12'({6'd0, msb}), r.prod << (6'd47 - msb));
  endfunction

  // Single precision addition, round to nearest even.
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [7:0]  d;
    logic [26:0] xa;
    logic [26:0] yb;
    logic [26:0] yal;
    logic [27:0] s;
    logic [27:0] sn;
    logic [4:0]  msb;
    msb = 5'd0;
    yal = '0;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
      return CanonNan;
    end
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    if (x[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    ux = unpack(x);
    uy = unpack(y);
    d  = ux[31:24] - uy[31:24];
    xa = {ux[23:0], 3'b000};
    yb = {uy[23:0], 3'b000};
    if (d >= 8'd27) begin
      yal = {26'd0, |yb};
    end else begin
      yal = (yb >> d[4:0]) | 27'(|(yb & ((27'd1 << d[4:0]) - 27'd1)));
    end
    if (x[31] ^ y[31]) s = {1'b0, xa} - {1'b0, yal};
    else s = {1'b0, xa} + {1'b0, yal};
    if (s == 28'd0) return ZeroBits;
    for (int i = 0; i < 28; i++) begin
      if (s[i]) msb = 5'(i);
    end
    sn = s << (5'd27 - msb);
    return round_pack(x[31],
                      12'({4'd0, ux[31:24]}) + 12'({7'd0, msb}) - 12'sd26,
                      {sn, 20'd0});
  endfunction

endpackage

// ----- design/rmm_mul.sv -----
module rmm_mul import rmm_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  mul_raw_t    raw_q;
  logic [31:0] p_q;

  // Mantissa product in the first stage, rounding in the second.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= mul_pre(a_i, b_i);
      p_q   <= mul_post(raw_q);
    end
  end

  assign p_o = p_q;

endmodule

// ----- design/rmm_lane.sv -----
module rmm_lane import rmm_pkg::*; (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NumTerms-1:0][31:0]    elem_i,
  input  logic [NumTerms-1:0][31:0]    col_i,
  input  third_sel_e                   third_sel_i,
  output logic [31:0]                  sum_o
);

  logic [NumTerms-1:0][31:0] prod;
  logic [31:0] s01_q;
  logic [31:0] p2_q;
  logic [31:0] p3_q;
  logic [31:0] s012_q;
  logic [31:0] p3_qq;
  logic [31:0] third;
  logic [31:0] sum_q;

  // One multiplier for each term of the dot product.
  for (genvar k = 0; k < NumTerms; k++) begin : g_mul
    rmm_mul u_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (elem_i[k]),
      .b_i   (col_i[k]),
      .p_o   (prod[k])
    );
  end

  // Third addend: the fourth product, the translation, or a negative zero
  // which leaves the sum unchanged.
  always_comb begin
    unique case (third_sel_i)
      THIRD_PROD:  third = p3_qq;
      THIRD_TRANS: third = col_i[3];
      THIRD_NONE:  third = NegZeroBits;
      default:     third = NegZeroBits;
    endcase
  end

  // Left to right sum, one addition per stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s01_q  <= fadd(prod[0], prod[1]);
      p2_q   <= prod[2];
      p3_q   <= prod[3];
      s012_q <= fadd(s01_q, p2_q);
      p3_qq  <= p3_q;
      sum_q  <= fadd(s012_q, third);
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- design/row_matrix_multiply_affine_full_top.sv -----
// Row times 4x4 matrix engine, single precision, four column lanes.
// Throughput: one request per cycle unless a waiting result stalls the whole
// pipeline; two multiplier stages and three adder stages per lane followed by
// the output register, all advancing together.
// Reset (asynchronous, active low) empties the pipeline and loads the identity.
module row_matrix_multiply_affine_full_top import rmm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [1:0]         row_index_i,
  input  logic [31:0]        elem0_i,
  input  logic [31:0]        elem1_i,
  input  logic [31:0]        elem2_i,
  input  logic [31:0]        elem3_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_out_o,
  output logic [31:0]        col0_o,
  output logic [31:0]        col1_o,
  output logic [31:0]        col2_o,
  output logic [31:0]        col3_o
);

  logic [NumRegs-1:0][63:0]            cfg_q;
  logic [NumStages:1]                  vld_q;
  ctrl_t                               ctrl_q [NumStages:1];
  logic                                out_valid_q;
  logic                                adv;
  logic [NumTerms-1:0][31:0]           elems;
  logic [NumLanes-1:0][NumTerms-1:0][31:0] cols;
  logic [NumLanes-1:0][31:0]           sums;
  logic [NumLanes-1:0][31:0]           res;
  third_sel_e                          third_sel;
  logic [1:0]                          row_q;
  logic [NumLanes-1:0][31:0]           col_q;

  // The whole pipeline moves unless a finished result is still waiting.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign elems      = {elem3_i, elem2_i, elem1_i, elem0_i};

  // Configuration registers hold the right matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_idx_i[$clog2(NumRegs)-1:0]] <= cfg_data_i;
    end
  end

  // Valid bits and control fields travel alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NumStages-1:1], in_valid_i};
      out_valid_q <= vld_q[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q[1] <= '{affine: req_type_i, row: row_index_i};
      for (int s = 2; s <= NumStages; s++) begin
        ctrl_q[s] <= ctrl_q[s-1];
      end
    end
  end

  // The last addition of a request sees its control in the fourth stage.
  always_comb begin
    if (!ctrl_q[4].affine) third_sel = THIRD_PROD;
    else if (ctrl_q[4].row == 2'd3) third_sel = THIRD_TRANS;
    else third_sel = THIRD_NONE;
  end

  // One lane per output column.
  for (genvar j = 0; j < NumLanes; j++) begin : g_lane
    for (genvar k = 0; k < NumTerms; k++) begin : g_col
      assign cols[j][k] = cfg_q[2*k + j/2][32*(j%2) +: 32];
    end

    rmm_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (adv),
      .elem_i      (elems),
      .col_i       (cols[j]),
      .third_sel_i (third_sel),
      .sum_o       (sums[j])
    );

    // Merge: canonical NaN, and the fixed last column in affine mode.
    always_comb begin
      if (ctrl_q[NumStages].affine && (j == NumLanes - 1)) begin
        res[j] = (ctrl_q[NumStages].row == 2'd3) ? OneBits : ZeroBits;
      end else if (is_nan(sums[j])) begin
        res[j] = CanonNan;
      end else begin
        res[j] = sums[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_q <= ctrl_q[NumStages].row;
      col_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_out_o   = row_q;
  assign col0_o      = col_q[0];
  assign col1_o      = col_q[1];
  assign col2_o      = col_q[2];
  assign col3_o      = col_q[3];

endmodule

// ----- sim/tb_row_matrix_multiply_affine_full_top.sv -----
module tb_row_matrix_multiply_affine_full_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmm_pkg::*;

  localparam logic REQ_FULL   = 1'b0;
  localparam logic REQ_AFFINE = 1'b1;

  // Register index is twice the matrix row plus the column half.
  localparam int HALF_COLS01 = 0;
  localparam int HALF_COLS23 = 1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_UNUSED = 4'd9;

  localparam int NUM_RANDOM   = 530;
  localparam int NUM_PHASES   = 5;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic        affine;
    logic [1:0]  row;
    logic [31:0] elem [4];
  } row_req_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] col [4];
  } row_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic req_type_i;
  logic [1:0] row_index_i;
  logic [31:0] elem0_i, elem1_i, elem2_i, elem3_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [1:0] row_out_o;
  logic [31:0] col0_o, col1_o, col2_o, col3_o;

  row_req_t pending_q [$];
  row_res_t product_q [$];
  logic [63:0] matrix_regs [NumRegs];
  int send_idle_pct;
  int recv_idle_pct;
  int sent_count;
  int checked_count;
  int error_count;

  row_matrix_multiply_affine_full_top u_dut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Widen a single bit pattern to a double, exactly.
  function automatic real single_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    end
    if (b[30:23] == 8'd0) begin
      if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'd0});
      // Subnormal: mantissa times two to the power -149.
      r = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0});
  endfunction

  // Round a double to single precision, nearest even, with subnormals.
  function automatic logic [31:0] real_to_single(real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    int ue;
    int sh;
    logic guard;
    logic sticky;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 52'd0) ? CanonNan : {d[63], 8'hFF, 23'd0};
    end
    if (d[62:0] == 63'd0) return {d[63], 31'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    ue  = int'(d[62:52]) - 1023;
    sh  = 29 + ((ue < -126) ? (-126 - ue) : 0);
    if (sh >= 64) begin
      kept = 64'd0;
      guard = 1'b0;
      sticky = 1'b1;
    end else begin
      kept = sig >> sh;
      guard = sig[sh-1];
      sticky = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    end
    kept = kept + 64'(guard & (sticky | kept[0]));
    if (ue < -126) return {d[63], 31'(kept)};
    if (kept[24]) begin
      kept = kept >> 1;
      ue++;
    end
    if (ue + 127 >= 255) return {d[63], 8'hFF, 23'd0};
    return {d[63], 8'(ue + 127), kept[22:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] x, logic [31:0] y);
    return real_to_single(single_to_real(x) * single_to_real(y));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] x, logic [31:0] y);
    return real_to_single(single_to_real(x) + single_to_real(y));
  endfunction

  function automatic logic [31:0] matrix_elem(int r, int c);
    logic [63:0] w;
    w = matrix_regs[2 * r + c / 2];
    return (c % 2) ? w[63:32] : w[31:0];
  endfunction

  // Product row: left to right sums, each step rounded.
  function automatic row_res_t row_product(row_req_t rq);
    row_res_t res;
    logic [31:0] acc;
    int terms;
    res.row = rq.row;
    terms = rq.affine ? 3 : 4;
    for (int j = 0; j < 4; j++) begin
      if (rq.affine && j == 3) begin
        res.col[j] = (rq.row == 2'd3) ? OneBits : ZeroBits;
      end else begin
        acc = sp_mul(rq.elem[0], matrix_elem(0, j));
        for (int k = 1; k < terms; k++) acc = sp_add(acc, sp_mul(rq.elem[k], matrix_elem(k, j)));
        if (rq.affine && rq.row == 2'd3) acc = sp_add(acc, matrix_elem(3, j));
        res.col[j] = (acc[30:23] == 8'hFF && acc[22:0] != 23'd0) ? CanonNan : acc;
      end
    end
    return res;
  endfunction

  // A float drawn with weight on special encodings and moderate magnitudes.
  function automatic logic [31:0] rand_float();
    logic sgn;
    sgn = 1'($urandom);
    case ($urandom_range(0, 11))
      0: return {sgn, 31'd0};
      1: return {sgn, 8'd0, 23'($urandom)};
      2: return {sgn, 8'hFF, 23'd0};
      3: return {sgn, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      4: return {sgn, 8'hFE, 23'($urandom)};
      5: return {sgn, 8'($urandom_range(1, 8)), 23'($urandom)};
      6: return 32'($urandom);
      default: return {sgn, 8'($urandom_range(112, 142)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_moderate();
    return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
  endfunction

  function automatic row_req_t make_req(logic affine, logic [1:0] row,
                                        logic [31:0] e0, logic [31:0] e1,
                                        logic [31:0] e2, logic [31:0] e3);
    row_req_t rq;
    rq.affine = affine;
    rq.row = row;
    rq.elem[0] = e0;
    rq.elem[1] = e1;
    rq.elem[2] = e2;
    rq.elem[3] = e3;
    return rq;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %08h, expected %08h", field, got, want);
    error_count++;
  endtask

  // One register write, applied to the local copy at the same edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < NumRegs) matrix_regs[idx] = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Request driver: a new request is offered only once the last one has gone.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) sent_count++;
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        row_req_t rq;
        rq = pending_q.pop_front();
        product_q.push_back(row_product(rq));
        in_valid_i  <= 1'b1;
        req_type_i  <= rq.affine;
        row_index_i <= rq.row;
        elem0_i     <= rq.elem[0];
        elem1_i     <= rq.elem[1];
        elem2_i     <= rq.elem[2];
        elem3_i     <= rq.elem[3];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (product_q.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, row_out_o}, 32'd0);
        end else begin
          row_res_t want;
          want = product_q.pop_front();
          checked_count++;
          if (row_out_o !== want.row) report_mismatch("row_out", 32'(row_out_o), 32'(want.row));
          if (col0_o !== want.col[0]) report_mismatch("col0", col0_o, want.col[0]);
          if (col1_o !== want.col[1]) report_mismatch("col1", col1_o, want.col[1]);
          if (col2_o !== want.col[2]) report_mismatch("col2", col2_o, want.col[2]);
          if (col3_o !== want.col[3]) report_mismatch("col3", col3_o, want.col[3]);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Idling pattern follows how many requests have gone in.
  always @(posedge clk_i) begin
    if (sent_count < 183) begin
      send_idle_pct <= 21;
      recv_idle_pct <= 74;
    end else if (sent_count < 366) begin
      send_idle_pct <= 74;
      recv_idle_pct <= 21;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // Stimulus: directed rows on the identity, then random phases per matrix.
  initial begin
    logic [31:0] specials [10];
    int per_phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_type_i = 1'b0;
    row_index_i = '0;
    elem0_i = '0;
    elem1_i = '0;
    elem2_i = '0;
    elem3_i = '0;
    send_idle_pct = 21;
    recv_idle_pct = 74;
    sent_count = 0;
    checked_count = 0;
    error_count = 0;
    for (int i = 0; i < NumRegs; i++) matrix_regs[i] = CfgReset[i];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    specials = '{ZeroBits, NegZeroBits, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
                 32'h807F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    for (int i = 0; i < 10; i++) begin
      pending_q.push_back(make_req(REQ_FULL, 2'(i), specials[i], specials[9 - i],
                                   specials[(i + 3) % 10], specials[(i + 6) % 10]));
      pending_q.push_back(make_req(REQ_AFFINE, 2'(i + 1), specials[(i + 5) % 10],
                                   specials[i], specials[9 - i], specials[(i + 2) % 10]));
    end
    // Infinity times zero, largest finite values, and opposite signs with negative zeros.
    pending_q.push_back(make_req(REQ_FULL, 2'd3, 32'h7F80_0000, ZeroBits, ZeroBits, ZeroBits));
    pending_q.push_back(make_req(REQ_AFFINE, 2'd3, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                                 ZeroBits, 32'hFFFF_FFFF));
    pending_q.push_back(make_req(REQ_FULL, 2'd0, OneBits, 32'hBF80_0000,
                                 NegZeroBits, NegZeroBits));

    per_phase = NUM_RANDOM / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait (pending_q.size() == 0 && !in_valid_i && product_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        for (int r = 0; r < 4; r++) begin
          for (int h = HALF_COLS01; h <= HALF_COLS23; h++) begin
            logic [63:0] word;
            case (ph)
              1: word = {rand_moderate(), rand_moderate()};
              2: word = {rand_float(), rand_float()};
              3: word = (h == HALF_COLS01) ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF;
              default: word = {rand_moderate(), rand_float()};
            endcase
            write_reg(CfgIdxW'(2 * r + h), word);
          end
        end
        if (ph == 3) write_reg(CFG_IDX_UNUSED, {2{32'h4000_0000}});
      end
      for (int i = 0; i < per_phase; i++) begin
        logic use_specials;
        use_specials = ($urandom_range(0, 3) == 0);
        pending_q.push_back(make_req(1'($urandom), 2'($urandom),
          use_specials ? rand_float() : rand_moderate(),
          use_specials ? rand_float() : rand_moderate(),
          use_specials ? rand_float() : rand_moderate(),
          use_specials ? rand_float() : rand_moderate()));
      end
    end

    wait (pending_q.size() == 0 && !in_valid_i && product_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d checked rows over %0d matrix settings, full and affine modes,",
             checked_count, NUM_PHASES);
    $display("with special encodings, subnormals and three back-pressure patterns.");
    if (error_count == 0 && product_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
